[hw/rtl/adsr_pkg.sv]
// Shared types, constants and helpers for the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

   // Envelope level width and the widths used for the saturating add
   localparam int LEVEL_BITS = 16;
   localparam int STEP_BITS  = 16;
   localparam int WIDE_BITS  = (LEVEL_BITS > STEP_BITS) ? LEVEL_BITS : STEP_BITS;
   localparam int SUM_BITS   = WIDE_BITS + 1;

   localparam int COUNT_BITS = 16;
   localparam int FIELD_BITS = 16;
   localparam int STAGE_CODE_BITS = 4;
   localparam int MODE_BITS = 6;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAGE_TIMES  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STAGE_STEPS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_DIVIDER = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE_FLAGS   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAUSE_LENGTH = 3'd4;

   // Mode flag bit positions
   localparam int MODE_ENABLE = 0;
   localparam int MODE_HOLD_A = 1;
   localparam int MODE_HOLD_D = 2;
   localparam int MODE_HOLD_S = 3;
   localparam int MODE_HOLD_R = 4;
   localparam int MODE_REPEAT = 5;

   // Slot of each timed stage in the packed time and step words
   localparam logic [1:0] SLOT_A = 2'd0;
   localparam logic [1:0] SLOT_D = 2'd1;
   localparam logic [1:0] SLOT_S = 2'd2;
   localparam logic [1:0] SLOT_R = 2'd3;

   // Envelope stages, one-hot; bit position equals the reported stage code
   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_A     = 11'b000_0000_0010,
      ST_HA    = 11'b000_0000_0100,
      ST_D     = 11'b000_0000_1000,
      ST_HD    = 11'b000_0001_0000,
      ST_S     = 11'b000_0010_0000,
      ST_HS    = 11'b000_0100_0000,
      ST_R     = 11'b000_1000_0000,
      ST_HR    = 11'b001_0000_0000,
      ST_END   = 11'b010_0000_0000,
      ST_PAUSE = 11'b100_0000_0000
   } stage_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] stage_times;
      logic [CSR_DATA_BITS-1:0] stage_steps;
      logic [COUNT_BITS-1:0]    tick_divider;
      logic [MODE_BITS-1:0]     mode_flags;
      logic [COUNT_BITS-1:0]    pause_length;
   } cfg_type;

   // Stage code from the one-hot stage: the index of the set bit
   function automatic logic [STAGE_CODE_BITS-1:0] stage_code(input stage_type s);
      logic [STAGE_CODE_BITS-1:0] code;
      code = '0;
      for (int i = 0; i < $bits(stage_type); i++) begin
         if (s[i]) begin
            code = code | STAGE_CODE_BITS'(i);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/adsr_if.sv]
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none

interface adsr_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface adsr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [adsr_pkg::LEVEL_BITS-1:0]      level;
   logic [adsr_pkg::STAGE_CODE_BITS-1:0] stage;
   logic                                 stepped;

   modport source (output valid, output level, output stage, output stepped, input ready);
   modport sink   (input valid, input level, input stage, input stepped, output ready);
endinterface

interface adsr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [adsr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [adsr_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/adsr_csr.sv]
// Configuration register bank of the ADSR envelope generator.
`default_nettype none

module adsr_csr (
   input  wire logic       clock,
   input  wire logic       reset,
   adsr_csr_if.sink        csr_chan,
   output adsr_pkg::cfg_type cfg
);

   adsr_pkg::cfg_type cfg_ff;
   adsr_pkg::cfg_type cfg_in;
   logic              write_en;

   // Writes are always taken; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;
   assign write_en       = csr_chan.valid;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (csr_chan.index)
            adsr_pkg::CSR_STAGE_TIMES:  cfg_in.stage_times  = csr_chan.data;
            adsr_pkg::CSR_STAGE_STEPS:  cfg_in.stage_steps  = csr_chan.data;
            adsr_pkg::CSR_TICK_DIVIDER:
               cfg_in.tick_divider = csr_chan.data[adsr_pkg::COUNT_BITS-1:0];
            adsr_pkg::CSR_MODE_FLAGS:
               cfg_in.mode_flags = csr_chan.data[adsr_pkg::MODE_BITS-1:0];
            adsr_pkg::CSR_PAUSE_LENGTH:
               cfg_in.pause_length = csr_chan.data[adsr_pkg::COUNT_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stage_times  <= '0;
         cfg_ff.stage_steps  <= '0;
         cfg_ff.tick_divider <= adsr_pkg::COUNT_BITS'(1);
         cfg_ff.mode_flags   <= '0;
         cfg_ff.pause_length <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/adsr_envelope_generator_unit.sv]
// Top level of the ADSR envelope generator: prescaler, stage machine, result register.
//
//  channel | dir | payload                 | transfer when
//  --------+-----+-------------------------+----------------------------
//  req     | in  | tick                    | req_chan.valid & ready
//  rsp     | out | level, stage, stepped   | rsp_chan.valid & ready
//  csr     | in  | index, data (64 bits)   | csr_chan.valid & ready
//
// One tick per cycle unless the result register stalls: the prescaler, stage machine and
// level adder form one combinational pass from the state registers into the result register,
// so a result is registered in the cycle after its request and a new tick can be taken each cycle.
// A request is taken while the result register is empty or being drained.
// Synchronous reset clears the state and the result valid, and resets the registers (divider to one).
// Register writes are always taken and apply from the next cycle.
`default_nettype none

module adsr_envelope_generator_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   adsr_req_if.sink   req_chan,
   adsr_rsp_if.source rsp_chan,
   adsr_csr_if.sink   csr_chan
);

   localparam int LB = adsr_pkg::LEVEL_BITS;
   localparam int CB = adsr_pkg::COUNT_BITS;
   localparam int FB = adsr_pkg::FIELD_BITS;
   localparam int WB = adsr_pkg::WIDE_BITS;
   localparam int SB = adsr_pkg::SUM_BITS;

   adsr_pkg::cfg_type cfg;

   // Envelope state
   logic [CB-1:0]       divider_count_ff, divider_count_in;
   adsr_pkg::stage_type stage_ff, stage_in;
   logic [LB-1:0]       level_ff, level_in;
   logic [CB-1:0]       stage_ticks_ff, stage_ticks_in;
   logic [CB-1:0]       pause_count_ff, pause_count_in;

   // Result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [LB-1:0]                        rsp_level_ff;
   logic [adsr_pkg::STAGE_CODE_BITS-1:0] rsp_stage_ff;
   logic                                 rsp_stepped_ff;

   logic                accept;
   logic                fire;
   logic [CB-1:0]       divider_inc;
   logic [1:0]          slot;
   logic                hold_en;
   adsr_pkg::stage_type hold_stage;
   adsr_pkg::stage_type next_stage;
   logic [FB-1:0]       step;
   logic [FB-1:0]       stage_time;
   logic [SB-1:0]       add_sum;
   logic [LB-1:0]       add_level;
   logic [WB-1:0]       level_wide;
   logic [WB-1:0]       step_wide;
   logic [LB-1:0]       sub_level;
   logic [CB-1:0]       ticks_inc;
   logic [CB-1:0]       pause_inc;

   adsr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // Prescaler
   always_comb begin
      divider_inc      = divider_count_ff + CB'(1);
      divider_count_in = divider_count_ff;
      fire             = 1'b0;
      if (accept && req_chan.tick) begin
         if (divider_inc == cfg.tick_divider) begin
            divider_count_in = '0;
            fire             = 1'b1;
         end else begin
            divider_count_in = divider_inc;
         end
      end
   end

   // Timed stage selection: slot, hold flag and the stages that follow
   always_comb begin
      unique case (stage_ff)
         adsr_pkg::ST_A: begin
            slot = adsr_pkg::SLOT_A; hold_en = cfg.mode_flags[adsr_pkg::MODE_HOLD_A];
            hold_stage = adsr_pkg::ST_HA; next_stage = adsr_pkg::ST_D;
         end
         adsr_pkg::ST_D: begin
            slot = adsr_pkg::SLOT_D; hold_en = cfg.mode_flags[adsr_pkg::MODE_HOLD_D];
            hold_stage = adsr_pkg::ST_HD; next_stage = adsr_pkg::ST_S;
         end
         adsr_pkg::ST_S: begin
            slot = adsr_pkg::SLOT_S; hold_en = cfg.mode_flags[adsr_pkg::MODE_HOLD_S];
            hold_stage = adsr_pkg::ST_HS; next_stage = adsr_pkg::ST_R;
         end
         adsr_pkg::ST_R: begin
            slot = adsr_pkg::SLOT_R; hold_en = cfg.mode_flags[adsr_pkg::MODE_HOLD_R];
            hold_stage = adsr_pkg::ST_HR; next_stage = adsr_pkg::ST_END;
         end
         default: begin
            slot = adsr_pkg::SLOT_A; hold_en = 1'b0;
            hold_stage = adsr_pkg::ST_IDLE; next_stage = adsr_pkg::ST_IDLE;
         end
      endcase
   end

   // Shared level arithmetic: saturating add for attack, floor-at-zero subtract
   always_comb begin
      step       = cfg.stage_steps[FB*slot +: FB];
      stage_time = cfg.stage_times[FB*slot +: FB];
      level_wide = WB'(level_ff);
      step_wide  = WB'(step);
      add_sum    = SB'(level_wide) + SB'(step_wide);
      if (|add_sum[SB-1:LB]) begin
         add_level = '1;
      end else begin
         add_level = add_sum[LB-1:0];
      end
      if (level_wide > step_wide) begin
         sub_level = LB'(level_wide - step_wide);
      end else begin
         sub_level = '0;
      end
      ticks_inc = stage_ticks_ff + CB'(1);
      pause_inc = pause_count_ff + CB'(1);
   end

   // Stage machine, advanced on each prescaler fire
   always_comb begin
      stage_in       = stage_ff;
      level_in       = level_ff;
      stage_ticks_in = stage_ticks_ff;
      pause_count_in = pause_count_ff;
      if (fire) begin
         unique case (stage_ff)
            adsr_pkg::ST_IDLE: begin
               level_in = '0;
               if (cfg.mode_flags[adsr_pkg::MODE_ENABLE]) begin
                  stage_in = adsr_pkg::ST_A;
               end
            end
            adsr_pkg::ST_A, adsr_pkg::ST_D, adsr_pkg::ST_S, adsr_pkg::ST_R: begin
               level_in = (stage_ff == adsr_pkg::ST_A) ? add_level : sub_level;
               if (ticks_inc >= stage_time) begin
                  stage_ticks_in = '0;
                  stage_in       = hold_en ? hold_stage : next_stage;
               end else begin
                  stage_ticks_in = ticks_inc;
               end
            end
            adsr_pkg::ST_HA: stage_in = adsr_pkg::ST_D;
            adsr_pkg::ST_HD: stage_in = adsr_pkg::ST_S;
            adsr_pkg::ST_HS: stage_in = adsr_pkg::ST_R;
            adsr_pkg::ST_HR: stage_in = adsr_pkg::ST_END;
            adsr_pkg::ST_END: begin
               stage_ticks_in = '0;
               pause_count_in = '0;
               stage_in = cfg.mode_flags[adsr_pkg::MODE_REPEAT] ?
                          adsr_pkg::ST_PAUSE : adsr_pkg::ST_IDLE;
            end
            adsr_pkg::ST_PAUSE: begin
               // level is kept across a repeat
               if (pause_inc >= cfg.pause_length) begin
                  pause_count_in = '0;
                  stage_ticks_in = '0;
                  stage_in       = adsr_pkg::ST_A;
               end else begin
                  pause_count_in = pause_inc;
               end
            end
            default: stage_in = adsr_pkg::ST_IDLE;
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_count_ff <= '0;
         stage_ff         <= adsr_pkg::ST_IDLE;
         level_ff         <= '0;
         stage_ticks_ff   <= '0;
         pause_count_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         divider_count_ff <= divider_count_in;
         stage_ff         <= stage_in;
         level_ff         <= level_in;
         stage_ticks_ff   <= stage_ticks_in;
         pause_count_ff   <= pause_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Result payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_level_ff   <= level_in;
         rsp_stage_ff   <= adsr_pkg::stage_code(stage_in);
         rsp_stepped_ff <= fire;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.level   = rsp_level_ff;
   assign rsp_chan.stage   = rsp_stage_ff;
   assign rsp_chan.stepped = rsp_stepped_ff;

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the ADSR envelope generator: directed and random tick streams.
module tb;

   localparam int HALF_PERIOD   = 2;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 64;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 100;
   localparam int PRINT_CAP     = 100;

   localparam int LB = adsr_pkg::LEVEL_BITS;
   localparam int CB = adsr_pkg::COUNT_BITS;
   localparam int FB = adsr_pkg::FIELD_BITS;

   // Stage codes as reported on the result channel
   typedef enum logic [adsr_pkg::STAGE_CODE_BITS-1:0] {
      SC_IDLE = 4'd0, SC_A, SC_HA, SC_D, SC_HD, SC_S, SC_HS, SC_R, SC_HR, SC_END, SC_PAUSE
   } env_stage_type;

   typedef struct packed {
      logic [LB-1:0]                        level;
      logic [adsr_pkg::STAGE_CODE_BITS-1:0] stage;
      logic                                 stepped;
   } env_result_type;

   logic clock = 1'b0;
   logic reset;

   adsr_req_if req_bus();
   adsr_rsp_if rsp_bus();
   adsr_csr_if csr_bus();

   adsr_envelope_generator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // Envelope state and register copy kept by the predictor
   adsr_pkg::cfg_type env_cfg;
   logic [CB-1:0]     div_count;
   logic [CB-1:0]     stage_ticks;
   logic [CB-1:0]     pause_count;
   logic [LB-1:0]     env_level;
   env_stage_type     env_stage;
   env_result_type    expected_results[$];

   int error_count  = 0;
   int stall_cycles = 0;
   bit idling       = 1'b1;
   bit hold_off_request = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP) begin
         $display("tb: mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
      end
      error_count++;
   endtask

   // One prescaled step of a timed stage (attack adds, the rest subtract)
   function automatic void run_timed(input logic [1:0] slot, input env_stage_type hold_stage,
                                     input env_stage_type next_stage);
      logic [FB-1:0] step;
      logic [FB-1:0] span;
      logic [LB:0]   sum;
      step = env_cfg.stage_steps[slot*FB +: FB];
      span = env_cfg.stage_times[slot*FB +: FB];
      if (slot == adsr_pkg::SLOT_A) begin
         sum = {1'b0, env_level} + (LB+1)'(step);
         if (sum > {1'b0, {LB{1'b1}}}) begin
            env_level = '1;
         end else begin
            env_level = sum[LB-1:0];
         end
      end else begin
         env_level = (env_level > step) ? env_level - step : '0;
      end
      stage_ticks = stage_ticks + 1'b1;
      if (stage_ticks >= span) begin
         stage_ticks = '0;
         if (env_cfg.mode_flags[adsr_pkg::MODE_HOLD_A + slot]) begin
            env_stage = hold_stage;
         end else begin
            env_stage = next_stage;
         end
      end
   endfunction

   function automatic void step_envelope();
      case (env_stage)
         SC_IDLE: begin
            env_level = '0;
            if (env_cfg.mode_flags[adsr_pkg::MODE_ENABLE]) env_stage = SC_A;
         end
         SC_A:  run_timed(adsr_pkg::SLOT_A, SC_HA, SC_D);
         SC_HA: env_stage = SC_D;
         SC_D:  run_timed(adsr_pkg::SLOT_D, SC_HD, SC_S);
         SC_HD: env_stage = SC_S;
         SC_S:  run_timed(adsr_pkg::SLOT_S, SC_HS, SC_R);
         SC_HS: env_stage = SC_R;
         SC_R:  run_timed(adsr_pkg::SLOT_R, SC_HR, SC_END);
         SC_HR: env_stage = SC_END;
         SC_END: begin
            stage_ticks = '0;
            pause_count = '0;
            env_stage = env_cfg.mode_flags[adsr_pkg::MODE_REPEAT] ? SC_PAUSE : SC_IDLE;
         end
         SC_PAUSE: begin
            // level is kept across a repeat
            pause_count = pause_count + 1'b1;
            if (pause_count >= env_cfg.pause_length) begin
               pause_count = '0;
               stage_ticks = '0;
               env_stage = SC_A;
            end
         end
         default: env_stage = SC_IDLE;
      endcase
   endfunction

   // Expected result of one accepted tick item
   function automatic void predict_tick(input logic tick);
      env_result_type r;
      r.stepped = 1'b0;
      if (tick) begin
         div_count = div_count + 1'b1;
         if (div_count == env_cfg.tick_divider) begin
            div_count = '0;
            r.stepped = 1'b1;
            step_envelope();
         end
      end
      r.level = env_level;
      r.stage = env_stage;
      expected_results.push_back(r);
   endfunction

   // Offer one tick item, after a random gap while idling; valid stays up after the transfer
   task automatic send_tick(input logic tick);
      int gap;
      gap = idling ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.tick  <= tick;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      predict_tick(tick);
   endtask

   // Drop the request and let every outstanding result drain
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [adsr_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [adsr_pkg::CSR_DATA_BITS-1:0] value);
      wait_quiet();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (index)
         adsr_pkg::CSR_STAGE_TIMES:  env_cfg.stage_times  = value;
         adsr_pkg::CSR_STAGE_STEPS:  env_cfg.stage_steps  = value;
         adsr_pkg::CSR_TICK_DIVIDER: env_cfg.tick_divider = value[CB-1:0];
         adsr_pkg::CSR_MODE_FLAGS:   env_cfg.mode_flags   = value[adsr_pkg::MODE_BITS-1:0];
         adsr_pkg::CSR_PAUSE_LENGTH: env_cfg.pause_length = value[CB-1:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Reset values: idle, no enable, divider of one
   task automatic test_after_reset();
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // Every stage with every hold, saturation at both ends, zero times and a repeat
   task automatic test_full_envelope();
      write_register(adsr_pkg::CSR_STAGE_TIMES, {16'd1, 16'd0, 16'd1, 16'd2});
      write_register(adsr_pkg::CSR_STAGE_STEPS, {16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF});
      write_register(adsr_pkg::CSR_PAUSE_LENGTH, 64'd0);
      write_register(adsr_pkg::CSR_MODE_FLAGS, 64'd63);
      for (int i = 0; i < 15; i++) begin
         send_tick(i != 6);
      end
   endtask

   // Enable cleared mid-envelope: it runs on to its end and then idles
   task automatic test_enable_dropped();
      write_register(adsr_pkg::CSR_MODE_FLAGS, 64'd0);
      repeat (6) send_tick(1'b1);
   endtask

   // Divider at its top, at zero, and lowered below the running count
   task automatic test_divider_edges();
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'hFFFF);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'd0);
      repeat (2) send_tick(1'b1);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'(div_count) + 64'd2);
      repeat (2) send_tick(1'b1);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'd3);
      repeat (2) send_tick(1'b1);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'd1);
      send_tick(1'b1);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'(div_count) + 64'd2);
      repeat (2) send_tick(1'b1);
      write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'd1);
   endtask

   // Longest times and pause, then shortened while the envelope is inside them
   task automatic test_long_settings();
      write_register(adsr_pkg::CSR_STAGE_TIMES, '1);
      write_register(adsr_pkg::CSR_PAUSE_LENGTH, 64'hFFFF);
      write_register(adsr_pkg::CSR_MODE_FLAGS,
                     64'((1 << adsr_pkg::MODE_ENABLE) | (1 << adsr_pkg::MODE_REPEAT)));
      repeat (2) send_tick(1'b1);
      write_register(adsr_pkg::CSR_STAGE_TIMES, 64'd0);
      repeat (6) send_tick(1'b1);
      write_register(adsr_pkg::CSR_PAUSE_LENGTH, 64'd2);
      send_tick(1'b1);
   endtask

   // Receiver holds off for a long stretch while ticks keep coming
   task automatic test_back_pressure();
      write_register(adsr_pkg::CSR_STAGE_TIMES, {16'd2, 16'd1, 16'd3, 16'd2});
      write_register(adsr_pkg::CSR_STAGE_STEPS, {16'h0800, 16'h0100, 16'h0400, 16'h3000});
      write_register(adsr_pkg::CSR_MODE_FLAGS, 64'd63);
      idling = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) send_tick($urandom_range(0, 7) != 0);
      idling = 1'b1;
   endtask

   // Random phases: short stage times, random steps, flags and small dividers
   task automatic test_random_envelopes();
      logic [adsr_pkg::CSR_DATA_BITS-1:0] spans;
      logic [adsr_pkg::CSR_DATA_BITS-1:0] steps;
      logic [adsr_pkg::MODE_BITS-1:0]     flags;
      logic [CB-1:0]                      divider;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int f = 0; f < 4; f++) begin
            spans[f*FB +: FB] = FB'($urandom_range(0, 6));
            case ($urandom_range(0, 3))
               0: steps[f*FB +: FB] = '0;
               1: steps[f*FB +: FB] = '1;
               2: steps[f*FB +: FB] = FB'($urandom_range(0, 255));
               default: steps[f*FB +: FB] = FB'($urandom);
            endcase
         end
         flags = adsr_pkg::MODE_BITS'($urandom_range(0, 63));
         if ($urandom_range(0, 4) != 0) flags[adsr_pkg::MODE_ENABLE] = 1'b1;
         // keep the divider above the running count so it fires soon
         divider = CB'($urandom_range(1, 3));
         if (div_count >= divider) divider = div_count + 1'b1;
         write_register(adsr_pkg::CSR_STAGE_TIMES, spans);
         write_register(adsr_pkg::CSR_STAGE_STEPS, steps);
         write_register(adsr_pkg::CSR_MODE_FLAGS, 64'(flags));
         write_register(adsr_pkg::CSR_PAUSE_LENGTH, 64'($urandom_range(0, 5)));
         write_register(adsr_pkg::CSR_TICK_DIVIDER, 64'(divider));
         idling = (phase % 3) != 2;
         repeat (PHASE_ITEMS) send_tick($urandom_range(0, 9) != 0);
      end
      idling = 1'b1;
   endtask

   // Result receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            gap = idling ? $urandom_range(0, 4) : 0;
            if (gap != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Result check against the oldest expectation
   always @(posedge clock) begin
      env_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'({rsp_bus.level, rsp_bus.stage}), '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.level !== want.level) begin
               report_mismatch("level", 64'(rsp_bus.level), 64'(want.level));
            end
            if (rsp_bus.stage !== want.stage) begin
               report_mismatch("stage", 64'(rsp_bus.stage), 64'(want.stage));
            end
            if (rsp_bus.stepped !== want.stepped) begin
               report_mismatch("stepped", 64'(rsp_bus.stepped), 64'(want.stepped));
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.tick  <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= adsr_pkg::CSR_STAGE_TIMES;
      csr_bus.data  <= '0;
      env_cfg = '0;
      env_cfg.tick_divider = 16'd1;
      div_count   = '0;
      stage_ticks = '0;
      pause_count = '0;
      env_level   = '0;
      env_stage   = SC_IDLE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_full_envelope();
      test_enable_dropped();
      test_divider_edges();
      test_long_settings();
      test_back_pressure();
      test_random_envelopes();

      wait_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
